// ===== design/nec_ir_pkg.sv =====
// ----------------------------------------------------------------------------
// nec_ir_pkg
// Shared types and constants for the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

   localparam int unsigned CNT_W      = 12;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned BIT_IDX_W  = 5;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 12;
   localparam int unsigned STATUS_W   = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [CNT_W-1:0]  LEADER_LOW_RST  = 12'd1000;
   localparam logic [CNT_W-1:0]  LEADER_HIGH_RST = 12'd500;
   localparam logic [CNT_W-1:0]  BIT_LOW_RST     = 12'd600;
   localparam logic [CNT_W-1:0]  ONE_THRESH_RST  = 12'd80;
   localparam logic [CNT_W-1:0]  BIT_HIGH_RST    = 12'd210;
   localparam logic [BYTE_W-1:0] TOGGLE_CMD_RST  = 8'h45;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEADER_LOW  = 3'd0,
      CSR_LEADER_HIGH = 3'd1,
      CSR_BIT_LOW     = 3'd2,
      CSR_ONE_THRESH  = 3'd3,
      CSR_BIT_HIGH    = 3'd4,
      CSR_TOGGLE_CMD  = 3'd5
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_VALID      = 2'd0,
      STATUS_CHECK_FAIL = 2'd1,
      STATUS_TIMEOUT    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_LEAD_LOW  = 3'd1,
      PH_LEAD_HIGH = 3'd2,
      PH_BIT_LOW   = 3'd3,
      PH_BIT_HIGH  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [CNT_W-1:0]  leader_low_limit;
      logic [CNT_W-1:0]  leader_high_limit;
      logic [CNT_W-1:0]  bit_low_limit;
      logic [CNT_W-1:0]  one_threshold;
      logic [CNT_W-1:0]  bit_high_limit;
      logic [BYTE_W-1:0] toggle_command;
   } cfg_type;

   typedef struct packed {
      logic              has_result;
      status_type        status;
      logic [BYTE_W-1:0] address;
      logic [BYTE_W-1:0] address_second;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] command_check;
      logic              drive_out;
   } result_type;

endpackage

// ===== design/nec_ir_csr.sv =====
// ----------------------------------------------------------------------------
// nec_ir_csr
// Configuration registers: pulse limits, one threshold and toggle command.
// ----------------------------------------------------------------------------
module nec_ir_csr
   import nec_ir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LEADER_LOW:  cfg_in.leader_low_limit  = csr_write_data;
            CSR_LEADER_HIGH: cfg_in.leader_high_limit = csr_write_data;
            CSR_BIT_LOW:     cfg_in.bit_low_limit     = csr_write_data;
            CSR_ONE_THRESH:  cfg_in.one_threshold     = csr_write_data;
            CSR_BIT_HIGH:    cfg_in.bit_high_limit    = csr_write_data;
            CSR_TOGGLE_CMD:  cfg_in.toggle_command    = csr_write_data[BYTE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_low_limit  <= LEADER_LOW_RST;
         cfg_ff.leader_high_limit <= LEADER_HIGH_RST;
         cfg_ff.bit_low_limit     <= BIT_LOW_RST;
         cfg_ff.one_threshold     <= ONE_THRESH_RST;
         cfg_ff.bit_high_limit    <= BIT_HIGH_RST;
         cfg_ff.toggle_command    <= TOGGLE_CMD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/nec_ir_core.sv =====
// ----------------------------------------------------------------------------
// nec_ir_core
// Frame state machine: times leader and bit pulses, shifts in 32 bits,
// checks the command complement and toggles the drive level.
// ----------------------------------------------------------------------------
module nec_ir_core
   import nec_ir_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic       level,
   output result_type result
);

   phase_type             phase_ff, phase_in;
   logic [CNT_W-1:0]      tick_ff, tick_in;
   logic [BIT_IDX_W-1:0]  bit_idx_ff, bit_idx_in;
   logic [BYTE_W-1:0]     bytes_ff [4];
   logic [BYTE_W-1:0]     bytes_in [4];
   logic                  last_level_ff, last_level_in;
   logic                  drive_ff, drive_in;

   logic                  do_count;
   logic                  use_exceed;
   logic [CNT_W-1:0]      cnt_base;
   logic [CNT_W-1:0]      cnt_limit;
   logic [CNT_W-1:0]      cnt_inc;
   logic                  abort;
   logic [1:0]            byte_sel;
   logic [BYTE_W-1:0]     shifted;
   logic [BIT_IDX_W-1:0]  bit_idx_next;

   assign byte_sel = bit_idx_ff[BIT_IDX_W-1:3];
   assign bit_idx_next = bit_idx_ff + 1'b1;

   always_comb begin
      shifted = {1'b0, bytes_ff[byte_sel][BYTE_W-1:1]};
      if (tick_ff >= cfg.one_threshold) begin
         shifted[BYTE_W-1] = 1'b1;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_idx_in    = bit_idx_ff;
      bytes_in      = bytes_ff;
      last_level_in = level;
      drive_in      = drive_ff;
      do_count      = 1'b0;
      use_exceed    = 1'b0;
      cnt_base      = tick_ff;
      cnt_limit     = cfg.leader_low_limit;
      result        = '0;
      result.status = STATUS_VALID;

      case (phase_ff)
         PH_IDLE: begin
            if (last_level_ff && !level) begin
               phase_in = PH_LEAD_LOW;
               cnt_base = '0;
               do_count = 1'b1;
            end
         end
         PH_LEAD_LOW: begin
            do_count = 1'b1;
            if (level) begin
               phase_in  = PH_LEAD_HIGH;
               cnt_base  = '0;
               cnt_limit = cfg.leader_high_limit;
            end
         end
         PH_LEAD_HIGH: begin
            do_count  = 1'b1;
            cnt_limit = cfg.leader_high_limit;
            if (!level) begin
               phase_in   = PH_BIT_LOW;
               bit_idx_in = '0;
               cnt_base   = '0;
               cnt_limit  = cfg.bit_low_limit;
            end
         end
         PH_BIT_LOW: begin
            do_count  = 1'b1;
            cnt_limit = cfg.bit_low_limit;
            if (level) begin
               phase_in   = PH_BIT_HIGH;
               cnt_base   = '0;
               cnt_limit  = cfg.bit_high_limit;
               use_exceed = 1'b1;
            end
         end
         PH_BIT_HIGH: begin
            if (level) begin
               do_count   = 1'b1;
               cnt_limit  = cfg.bit_high_limit;
               use_exceed = 1'b1;
            end else begin
               bytes_in[byte_sel] = shifted;
               bit_idx_in         = bit_idx_next;
               if (bit_idx_next == '0) begin
                  phase_in = PH_IDLE;
                  tick_in  = '0;
                  result.has_result = 1'b1;
                  if (bytes_in[2] != ~bytes_in[3]) begin
                     bytes_in      = '{default: '0};
                     result.status = STATUS_CHECK_FAIL;
                  end else begin
                     result.status = STATUS_VALID;
                     if (bytes_in[2] == cfg.toggle_command) begin
                        drive_in = ~drive_ff;
                     end
                  end
               end else begin
                  phase_in  = PH_BIT_LOW;
                  cnt_base  = '0;
                  do_count  = 1'b1;
                  cnt_limit = cfg.bit_low_limit;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
      endcase

      cnt_inc = cnt_base + 1'b1;
      abort   = do_count && ((cnt_base == CNT_MAX) ||
                (use_exceed ? (cnt_inc > cnt_limit) : (cnt_inc >= cnt_limit)));

      if (do_count) begin
         tick_in = cnt_inc;
      end

      if (abort) begin
         phase_in          = PH_IDLE;
         tick_in           = '0;
         bit_idx_in        = '0;
         result.has_result = 1'b1;
         result.status     = STATUS_TIMEOUT;
      end

      result.address        = bytes_in[0];
      result.address_second = bytes_in[1];
      result.command        = bytes_in[2];
      result.command_check  = bytes_in[3];
      result.drive_out      = drive_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         bit_idx_ff    <= '0;
         bytes_ff      <= '{default: '0};
         last_level_ff <= 1'b1;
         drive_ff      <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         bit_idx_ff    <= bit_idx_in;
         bytes_ff      <= bytes_in;
         last_level_ff <= last_level_in;
         drive_ff      <= drive_in;
      end
   end

endmodule

// ===== design/nec_ir_out.sv =====
// ----------------------------------------------------------------------------
// nec_ir_out
// Result register holding one decoded word until the consumer takes it.
// ----------------------------------------------------------------------------
module nec_ir_out
   import nec_ir_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       slot_free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type held
);

   logic       valid_ff, valid_in;
   result_type held_ff;

   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         held_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign held      = held_ff;

endmodule

// ===== design/nec_ir_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_top
// NEC infrared remote frame decoder, one line sample per request.
// ----------------------------------------------------------------------------
// Takes one line sample per cycle while req_stall is low. A sample is captured
// in an input register and decoded by a step of the frame state machine once it
// can advance; a frame result is loaded into an output register. Sustained rate
// is one sample per cycle while no held result is stalled; req_stall rises only
// while a held result is stalled and the pending sample would produce another
// one. Limits and the toggle command are written through the csr_ port; the
// user must write them only while idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_top
   import nec_ir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_ir_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [BYTE_W-1:0]     rsp_address,
   output logic [BYTE_W-1:0]     rsp_address_second,
   output logic [BYTE_W-1:0]     rsp_command,
   output logic [BYTE_W-1:0]     rsp_command_check,
   output logic                  rsp_drive_out
);

   cfg_type    cfg;
   result_type result;
   result_type held;
   logic       in_valid_ff, in_valid_in;
   logic       in_level_ff;
   logic       slot_free;
   logic       advance;
   logic       req_take;

   nec_ir_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   assign advance   = in_valid_ff && (!result.has_result || slot_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_level_ff <= req_ir_level;
      end
   end

   nec_ir_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .level  (in_level_ff),
      .result (result)
   );

   nec_ir_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && result.has_result),
      .result    (result),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .held      (held)
   );

   assign rsp_status         = held.status;
   assign rsp_address        = held.address;
   assign rsp_address_second = held.address_second;
   assign rsp_command        = held.command;
   assign rsp_command_check  = held.command_check;
   assign rsp_drive_out      = held.drive_out;

endmodule
